>>> rtl/ich_pkg.sv
// ich_pkg: shared types, codes and default constants for the item class
// support histogram. No dependencies; used by the core, ich_front and ich_back.
`timescale 1ns / 1ps

package ich_pkg;

  localparam int ITEM_IDS_DEF = 4096;
  localparam int CLASSES_DEF = 4;
  localparam int QUEUE_DEPTH = 4;

  localparam int ITEM_W = 12;
  localparam int CFG_W = 3;
  localparam int COUNT_W = 32;
  localparam int LEN_W = 16;
  localparam int BOUND_W = 13;

  localparam logic [CFG_W-1:0] NUM_CLASSES_RESET = 3'd2;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  typedef enum logic [1:0] {
    ERR_OK = 2'd0,
    ERR_ITEM = 2'd1,
    ERR_CLASS = 2'd2
  } err_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_FETCH,
    BK_UPDATE
  } back_state_t;

  // Everything the back part needs besides the counter address.
  typedef struct packed {
    logic is_data;
    err_t err;
    logic [COUNT_W-1:0] trans;
    logic [LEN_W-1:0] len_bound;
    logic [BOUND_W-1:0] item_bound;
  } result_t;

endpackage

>>> rtl/item_class_support_histogram_core.sv
// Item class support histogram: one result per request, in order.
// The back part takes one queue entry at a time: FETCH reads its counter,
// UPDATE loads the result and, for a good data item, writes back the raised
// count. A 4-entry queue lets the front keep accepting while it works.
// Reset: synchronous; afterwards a clearing pass writes zero to every counter
// (ITEM_IDS*CLASSES of them, 16384 by default), with input stalled meanwhile.
`timescale 1ns / 1ps

module item_class_support_histogram_core #(
  parameter int ITEM_IDS = ich_pkg::ITEM_IDS_DEF,
  parameter int CLASSES = ich_pkg::CLASSES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [ich_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        kind,
  input  logic [ich_pkg::ITEM_W-1:0]  item_id,
  input  logic                        starts_transaction,
  input  logic [1:0]                  query_class,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [ich_pkg::COUNT_W-1:0] support_count,
  output logic [ich_pkg::COUNT_W-1:0] transaction_count,
  output logic [ich_pkg::LEN_W-1:0]   length_bound,
  output logic [ich_pkg::BOUND_W-1:0] item_bound,
  output logic [1:0]                  error
);

  localparam int DEPTH = ITEM_IDS * CLASSES;
  localparam int AW = $clog2(DEPTH);
  localparam int EW = $bits(ich_pkg::result_t) + AW;

  logic clearing;
  logic q_full;
  logic q_valid;
  logic q_pop;
  logic push;
  ich_pkg::result_t push_res;
  logic [AW-1:0] push_addr;
  logic [EW-1:0] pop_data;
  ich_pkg::result_t q_res;
  logic [AW-1:0] q_addr;

  assign cfg_ready = 1'b1;

  ich_front #(
    .ITEM_IDS(ITEM_IDS),
    .CLASSES (CLASSES),
    .AW      (AW)
  ) u_front (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .kind              (kind),
    .item_id           (item_id),
    .starts_transaction(starts_transaction),
    .query_class       (query_class),
    .clearing          (clearing),
    .q_full            (q_full),
    .push              (push),
    .push_res          (push_res),
    .push_addr         (push_addr)
  );

  ich_queue #(
    .WIDTH(EW),
    .DEPTH(ich_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data({push_res, push_addr}),
    .pop      (q_pop),
    .pop_data (pop_data),
    .full     (q_full),
    .not_empty(q_valid)
  );

  assign q_res = pop_data[EW-1:AW];
  assign q_addr = pop_data[AW-1:0];

  ich_back #(
    .DEPTH(DEPTH)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .q_valid          (q_valid),
    .q_res            (q_res),
    .q_addr           (q_addr),
    .q_pop            (q_pop),
    .clearing         (clearing),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .support_count    (support_count),
    .transaction_count(transaction_count),
    .length_bound     (length_bound),
    .item_bound       (item_bound),
    .error            (error)
  );

  // Nothing may be queued while the counters are still being cleared.
  a_no_queue_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !q_valid)
    else $error("queue holds a request during the clearing pass");

  // No result can come out of the clearing pass.
  a_no_result_after_clear: assert property (@(posedge clk) disable iff (rst)
    $fell(clearing) |-> !out_valid)
    else $error("result appeared during the clearing pass");

  // The back part only pops when the queue has something.
  a_pop_needs_entry: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid && !clearing)
    else $error("pop from an empty queue or during clearing");

endmodule

>>> rtl/ich_ram.sv
// ich_ram: generic single-clock RAM, one write port, one read port with
// registered read data. No dependencies.
`timescale 1ns / 1ps

module ich_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/ich_queue.sv
// ich_queue: short register FIFO between the front and back parts.
// No dependencies.
`timescale 1ns / 1ps

module ich_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             not_empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] fill;

  assign full = (fill == CW'(DEPTH));
  assign not_empty = (fill != '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

>>> rtl/ich_front.sv
// ich_front: accepts requests, checks them, keeps the transaction state and
// the class count register, and forms queue entries. Depends on ich_pkg.
`timescale 1ns / 1ps

module ich_front #(
  parameter int ITEM_IDS = ich_pkg::ITEM_IDS_DEF,
  parameter int CLASSES = ich_pkg::CLASSES_DEF,
  parameter int AW = 14
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [ich_pkg::CFG_W-1:0]  cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       kind,
  input  logic [ich_pkg::ITEM_W-1:0] item_id,
  input  logic                       starts_transaction,
  input  logic [1:0]                 query_class,
  input  logic                       clearing,
  input  logic                       q_full,
  output logic                       push,
  output ich_pkg::result_t           push_res,
  output logic [AW-1:0]              push_addr
);

  localparam int CW = (CLASSES > 1) ? $clog2(CLASSES) : 1;
  localparam logic [16:0] ItemLimit = 17'(ITEM_IDS);

  logic [ich_pkg::CFG_W-1:0] num_classes;
  logic [ich_pkg::CFG_W-1:0] ncls;
  logic [ich_pkg::ITEM_W-1:0] current_class, current_class_next;
  logic [ich_pkg::LEN_W-1:0] current_length, current_length_next;
  logic [ich_pkg::COUNT_W-1:0] transactions_seen, transactions_seen_next;
  logic [ich_pkg::LEN_W-1:0] longest_length, longest_length_next;
  logic [ich_pkg::ITEM_W-1:0] largest_item, largest_item_next;

  logic accept;
  logic item_bad;
  logic data_cls_bad;
  logic qry_cls_bad;
  logic upd;
  ich_pkg::err_t err;
  logic [ich_pkg::ITEM_W-1:0] cls_eff;
  logic [ich_pkg::ITEM_W-1:0] cls_sel;
  logic [ich_pkg::LEN_W-1:0] len_base;
  logic [ich_pkg::LEN_W-1:0] len_inc;

  assign in_stall = q_full || clearing;
  assign accept = in_valid && !in_stall;
  assign push = accept;

  assign ncls = (int'(num_classes) > CLASSES) ? ich_pkg::CFG_W'(CLASSES) : num_classes;

  // An opening item relabels the transaction before it is checked itself.
  assign cls_eff = starts_transaction ? item_id : current_class;
  assign len_base = starts_transaction ? '0 : current_length;
  assign len_inc = (len_base == ich_pkg::LEN_MAX) ? len_base : len_base + 1'b1;

  assign item_bad = ({5'b0, item_id} >= ItemLimit);
  assign data_cls_bad = (cls_eff >= {9'b0, ncls});
  assign qry_cls_bad = ({1'b0, query_class} >= ncls);

  always_comb begin
    if (item_bad) begin
      err = ich_pkg::ERR_ITEM;
    end else if (kind ? qry_cls_bad : data_cls_bad) begin
      err = ich_pkg::ERR_CLASS;
    end else begin
      err = ich_pkg::ERR_OK;
    end
  end

  assign upd = accept && !kind && (err == ich_pkg::ERR_OK);

  always_comb begin
    current_class_next = current_class;
    current_length_next = current_length;
    transactions_seen_next = transactions_seen;
    longest_length_next = longest_length;
    largest_item_next = largest_item;
    if (accept && !kind) begin
      current_class_next = cls_eff;
      current_length_next = len_base;
    end
    if (upd) begin
      current_length_next = len_inc;
      if (len_base == '0 && transactions_seen != ich_pkg::COUNT_MAX) begin
        transactions_seen_next = transactions_seen + 1'b1;
      end
      if (len_inc > longest_length) begin
        longest_length_next = len_inc;
      end
      if (item_id > largest_item) begin
        largest_item_next = item_id;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_classes <= ich_pkg::NUM_CLASSES_RESET;
      current_class <= '0;
      current_length <= '0;
      transactions_seen <= '0;
      longest_length <= '0;
      largest_item <= '0;
    end else begin
      if (cfg_we) begin
        num_classes <= cfg_data;
      end
      current_class <= current_class_next;
      current_length <= current_length_next;
      transactions_seen <= transactions_seen_next;
      longest_length <= longest_length_next;
      largest_item <= largest_item_next;
    end
  end

  // Counter address; only meaningful when the request passed its checks.
  assign cls_sel = kind ? {10'b0, query_class} : cls_eff;
  assign push_addr = AW'(AW'(item_id) * AW'(CLASSES)) + AW'(cls_sel[CW-1:0]);

  always_comb begin
    push_res.is_data = !kind;
    push_res.err = err;
    push_res.trans = transactions_seen_next;
    push_res.len_bound = (longest_length_next == ich_pkg::LEN_MAX) ?
                         ich_pkg::LEN_MAX : longest_length_next + 1'b1;
    push_res.item_bound = {1'b0, largest_item_next} + 1'b1;
  end

endmodule

>>> rtl/ich_back.sv
// ich_back: clears the support counter RAM after reset, then performs the
// read-modify-write or read for each queue entry and holds the result.
// Depends on ich_pkg and ich_ram.
`timescale 1ns / 1ps

module ich_back #(
  parameter int DEPTH = 16384
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  ich_pkg::result_t              q_res,
  input  logic [$clog2(DEPTH)-1:0]      q_addr,
  output logic                          q_pop,
  output logic                          clearing,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ich_pkg::COUNT_W-1:0]   support_count,
  output logic [ich_pkg::COUNT_W-1:0]   transaction_count,
  output logic [ich_pkg::LEN_W-1:0]     length_bound,
  output logic [ich_pkg::BOUND_W-1:0]   item_bound,
  output logic [1:0]                    error
);

  localparam int AW = $clog2(DEPTH);

  ich_pkg::back_state_t state, state_next;
  logic [AW-1:0] clr_addr;
  ich_pkg::result_t cur_res;
  logic [AW-1:0] cur_addr;

  logic we;
  logic [AW-1:0] waddr;
  logic [ich_pkg::COUNT_W-1:0] wdata;
  logic re;
  logic [ich_pkg::COUNT_W-1:0] rdata;
  logic load;
  logic slot_free;
  logic [ich_pkg::COUNT_W-1:0] inc;
  logic [ich_pkg::COUNT_W-1:0] count;

  ich_ram #(
    .WIDTH(ich_pkg::COUNT_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(q_addr),
    .rdata(rdata)
  );

  assign slot_free = !out_valid || !out_stall;
  assign clearing = (state == ich_pkg::BK_CLEAR);
  assign inc = (rdata == ich_pkg::COUNT_MAX) ? rdata : rdata + 1'b1;

  always_comb begin
    if (cur_res.err != ich_pkg::ERR_OK) begin
      count = '0;
    end else if (cur_res.is_data) begin
      count = inc;
    end else begin
      count = rdata;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ich_pkg::BK_CLEAR: begin
        if (clr_addr == AW'(DEPTH - 1)) begin
          state_next = ich_pkg::BK_FETCH;
        end
      end
      ich_pkg::BK_FETCH: begin
        if (q_valid) begin
          state_next = ich_pkg::BK_UPDATE;
        end
      end
      ich_pkg::BK_UPDATE: begin
        if (slot_free) begin
          state_next = ich_pkg::BK_FETCH;
        end
      end
      default: state_next = ich_pkg::BK_CLEAR;
    endcase
  end

  always_comb begin
    we = 1'b0;
    waddr = cur_addr;
    wdata = inc;
    re = 1'b0;
    q_pop = 1'b0;
    load = 1'b0;
    unique case (state)
      ich_pkg::BK_CLEAR: begin
        we = 1'b1;
        waddr = clr_addr;
        wdata = '0;
      end
      ich_pkg::BK_FETCH: begin
        q_pop = q_valid;
        re = q_valid;
      end
      ich_pkg::BK_UPDATE: begin
        // Read data holds here until the result slot frees up.
        load = slot_free;
        we = slot_free && cur_res.is_data && (cur_res.err == ich_pkg::ERR_OK);
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ich_pkg::BK_CLEAR;
      clr_addr <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ich_pkg::BK_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_res <= q_res;
      cur_addr <= q_addr;
    end
    if (load) begin
      support_count <= count;
      transaction_count <= cur_res.trans;
      length_bound <= cur_res.len_bound;
      item_bound <= cur_res.item_bound;
      error <= cur_res.err;
    end
  end

endmodule

>>> test/item_class_support_histogram_core_tb.sv
// Self-checking testbench for item_class_support_histogram_core: predicts each
// result from its own mirror of the support table, transaction state and class
// register. Depends on ich_pkg and the core RTL only.
`timescale 1ns / 1ps

module item_class_support_histogram_core_tb;
  import ich_pkg::*;

  localparam int CLK_PERIOD = 10;
  localparam int ITEMS = ITEM_IDS_DEF;
  localparam int CLS = CLASSES_DEF;
  // The clearing pass after reset zeroes all ITEMS*CLS counters with the input stalled.
  localparam int STALL_LIMIT = 3 * ITEMS * CLS + 1000;
  localparam int DRAIN_CYCLES = 12;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam int STALL_NONE = 0;
  localparam int STALL_JITTER = 1;
  localparam int STALL_SOLID = 2;

  typedef struct packed {
    logic              kind;
    logic [ITEM_W-1:0] item;
    logic              opens;
    logic [1:0]        qcls;
  } request_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [COUNT_W-1:0] trans;
    logic [LEN_W-1:0]   len_bound;
    logic [BOUND_W-1:0] item_bound;
    err_t               err;
  } tally_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CFG_W-1:0]   cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               kind = KIND_DATA;
  logic [ITEM_W-1:0]  item_id = '0;
  logic               starts_transaction = 1'b0;
  logic [1:0]         query_class = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [COUNT_W-1:0] support_count;
  logic [COUNT_W-1:0] transaction_count;
  logic [LEN_W-1:0]   length_bound;
  logic [BOUND_W-1:0] item_bound;
  logic [1:0]         error;

  item_class_support_histogram_core u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .kind(kind),
    .item_id(item_id),
    .starts_transaction(starts_transaction),
    .query_class(query_class),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .support_count(support_count),
    .transaction_count(transaction_count),
    .length_bound(length_bound),
    .item_bound(item_bound),
    .error(error)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Mirror of the block's state.
  bit [COUNT_W-1:0] support_mirror [0:ITEMS*CLS-1];
  bit [CFG_W-1:0]   classes_reg = NUM_CLASSES_RESET;
  bit [ITEM_W-1:0]  open_class = '0;
  bit [LEN_W-1:0]   run_len = '0;
  bit [COUNT_W-1:0] trans_seen = '0;
  bit [LEN_W-1:0]   longest = '0;
  bit [ITEM_W-1:0]  top_item = '0;

  request_t request_queue[$];
  tally_t   tally_due[$];
  request_t next_req;
  tally_t   exp_tally;
  int       pushed_total = 0;
  int       taken_total = 0;
  int       fail_count = 0;
  int       idle_cycles = 0;
  int       burst_left = 0;
  int       gap_left = 0;
  int       stall_left = 0;
  int       stall_mode = STALL_NONE;
  logic     in_taken = 1'b0;
  logic     cfg_taken = 1'b0;

  function automatic tally_t tally_request(request_t r);
    int unsigned ncls;
    int unsigned idx;
    tally_t t;
    ncls = (classes_reg > CLS) ? CLS : classes_reg;
    t = '0;
    t.err = ERR_OK;
    if (r.kind == KIND_READ) begin
      if (r.item >= ITEMS) t.err = ERR_ITEM;
      else if (r.qcls >= ncls) t.err = ERR_CLASS;
      else t.count = support_mirror[r.item * CLS + r.qcls];
    end else begin
      // The label is taken before the item itself is checked.
      if (r.opens) begin
        run_len = '0;
        open_class = r.item;
      end
      if (r.item >= ITEMS) begin
        t.err = ERR_ITEM;
      end else if (open_class >= ncls) begin
        t.err = ERR_CLASS;
      end else begin
        idx = r.item * CLS + open_class;
        if (run_len == 0 && trans_seen != '1) trans_seen++;
        if (run_len != '1) run_len++;
        if (run_len > longest) longest = run_len;
        if (r.item > top_item) top_item = r.item;
        if (support_mirror[idx] != '1) support_mirror[idx]++;
        t.count = support_mirror[idx];
      end
    end
    t.trans = trans_seen;
    t.len_bound = (longest == '1) ? longest : longest + 1'b1;
    t.item_bound = {1'b0, top_item} + 1'b1;
    return t;
  endfunction

  // Request driver: bursts of random length with random gaps between them.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (request_queue.size() > 0) begin
        next_req = request_queue.pop_front();
        in_valid <= 1'b1;
        kind <= next_req.kind;
        item_id <= next_req.item;
        starts_transaction <= next_req.opens;
        query_class <= next_req.qcls;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 5) : 0;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result stall: runs of no stall, jittery stall and solid stall.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(STALL_NONE, STALL_SOLID);
      stall_left = $urandom_range(1, 30);
    end
    stall_left--;
    case (stall_mode)
      STALL_NONE: out_stall <= 1'b0;
      STALL_JITTER: out_stall <= 1'($urandom_range(0, 1));
      default: out_stall <= (stall_left < 6);
    endcase
  end

  // Monitor: predict on request acceptance, check on result acceptance.
  always @(posedge clk) begin
    in_taken <= !rst && in_valid && !in_stall;
    cfg_taken <= !rst && cfg_valid && cfg_ready;
    if (!rst) begin
      if (cfg_valid && cfg_ready) classes_reg = cfg_data;
      if (in_valid && !in_stall) begin
        tally_due.push_back(tally_request({kind, item_id, starts_transaction, query_class}));
        taken_total++;
      end
      if (out_valid && !out_stall) begin
        if (tally_due.size() == 0) begin
          $error("result with no request outstanding");
          fail_count++;
        end else begin
          exp_tally = tally_due.pop_front();
          if (support_count !== exp_tally.count) begin
            $error("support_count: expected %0d, got %0d", exp_tally.count, support_count);
            fail_count++;
          end
          if (transaction_count !== exp_tally.trans) begin
            $error("transaction_count: expected %0d, got %0d", exp_tally.trans,
                   transaction_count);
            fail_count++;
          end
          if (length_bound !== exp_tally.len_bound) begin
            $error("length_bound: expected %0d, got %0d", exp_tally.len_bound, length_bound);
            fail_count++;
          end
          if (item_bound !== exp_tally.item_bound) begin
            $error("item_bound: expected %0d, got %0d", exp_tally.item_bound, item_bound);
            fail_count++;
          end
          if (error !== exp_tally.err) begin
            $error("error: expected %0d, got %0d", exp_tally.err, error);
            fail_count++;
          end
        end
      end
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic push_request(logic k, logic [ITEM_W-1:0] it, logic op, logic [1:0] qc);
    request_t r;
    r.kind = k;
    r.item = it;
    r.opens = op;
    r.qcls = qc;
    request_queue.push_back(r);
    pushed_total++;
  endtask

  task automatic wait_idle();
    while (taken_total != pushed_total || tally_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_classes(logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    while (!cfg_taken) @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [ITEM_W-1:0] pick_item();
    case ($urandom_range(0, 9))
      0: return ITEM_W'($urandom_range(0, ITEMS - 1));
      1: return '1;
      default: return ITEM_W'($urandom_range(0, 31));
    endcase
  endfunction

  task automatic maybe_read();
    if ($urandom_range(0, 5) == 0)
      push_request(KIND_READ, pick_item(), 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
  endtask

  // Mostly well-formed transactions with random content; some stray items,
  // invalid labels and reads mixed in.
  task automatic random_phase(int n);
    int start_count;
    int len;
    logic [ITEM_W-1:0] label;
    start_count = pushed_total;
    // Continue whatever transaction is open under the new class count.
    repeat (2) push_request(KIND_DATA, pick_item(), 1'b0, 2'($urandom_range(0, 3)));
    while (pushed_total - start_count < n) begin
      case ($urandom_range(0, 9))
        7, 8: begin
          push_request(KIND_READ, pick_item(), 1'($urandom_range(0, 1)),
                       2'($urandom_range(0, 3)));
        end
        9: begin
          push_request(KIND_DATA, pick_item(), 1'b0, 2'($urandom_range(0, 3)));
        end
        default: begin
          label = ($urandom_range(0, 4) == 0) ? ITEM_W'($urandom_range(0, ITEMS - 1))
                                                : ITEM_W'($urandom_range(0, 3));
          len = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
          push_request(KIND_DATA, label, 1'b1, 2'($urandom_range(0, 3)));
          repeat (len) begin
            push_request(KIND_DATA, pick_item(), 1'b0, 2'($urandom_range(0, 3)));
            maybe_read();
          end
        end
      endcase
    end
  endtask

  logic [CFG_W-1:0] class_settings [0:7] = '{3'd4, 3'd0, 3'd1, 3'd7, 3'd3, 3'd5, 3'd2, 3'd4};

  initial begin
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // Directed part under the reset class count of two.
    push_request(KIND_READ, 12'd0, 1'b0, 2'd0);
    push_request(KIND_DATA, 12'd5, 1'b0, 2'd3);      // before any label: class 0
    push_request(KIND_DATA, 12'hFFF, 1'b0, 2'd0);    // largest item id
    push_request(KIND_DATA, 12'd1, 1'b1, 2'd0);      // open class 1
    push_request(KIND_DATA, 12'd0, 1'b0, 2'd0);
    push_request(KIND_DATA, 12'hFFF, 1'b0, 2'd0);
    push_request(KIND_DATA, 12'd7, 1'b0, 2'd0);
    push_request(KIND_DATA, 12'd2, 1'b1, 2'd0);      // label beyond the class count
    push_request(KIND_DATA, 12'd3, 1'b0, 2'd0);
    push_request(KIND_DATA, 12'hFFF, 1'b1, 2'd0);    // widest bad label
    push_request(KIND_DATA, 12'd0, 1'b1, 2'd0);
    push_request(KIND_DATA, 12'd5, 1'b0, 2'd0);
    push_request(KIND_DATA, 12'd5, 1'b0, 2'd0);
    push_request(KIND_READ, 12'd5, 1'b0, 2'd0);
    push_request(KIND_READ, 12'd5, 1'b0, 2'd1);
    push_request(KIND_READ, 12'hFFF, 1'b0, 2'd3);    // read of a class out of range
    push_request(KIND_READ, 12'hFFF, 1'b1, 2'd1);
    push_request(KIND_READ, 12'd0, 1'b0, 2'd2);
    push_request(KIND_DATA, 12'd1, 1'b1, 2'd3);      // single-item transaction
    push_request(KIND_READ, 12'd1, 1'b0, 2'd1);
    push_request(KIND_READ, 12'd0, 1'b0, 2'd1);
    wait_idle();

    foreach (class_settings[i]) begin
      write_classes(class_settings[i]);
      random_phase(250);
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
